### rtl/smrd_pkg.sv
// Shared types and constants for the sprite mask run-length row decoder.
`timescale 1ns / 1ps
package smrd_pkg;

  localparam int unsigned SpaceW = 16;
  localparam int unsigned WidthW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SpaceW-1:0] BlankRowMark = 16'hFFFF;
  localparam logic [ByteW-1:0]  FullGray     = 8'hFF;
  localparam logic [ByteW-1:0]  ZeroGray     = 8'h00;

  typedef enum logic [1:0] {
    OP_LAYER_START = 2'd0,
    OP_ROW_BEGIN   = 2'd1,
    OP_STREAM_BYTE = 2'd2,
    OP_UNUSED      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_BG_RUN  = 2'b00,
    CMD_DRAW    = 2'b01,
    CMD_BAD     = 2'b10,
    CMD_END_ROW = 2'b11
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_LAYER     = 2'd0,
    KIND_ROW       = 2'd1,
    KIND_BLANK_ROW = 2'd2,
    KIND_BYTE      = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAYER_WIDTH = 2'd0,
    REG_LAYER_KIND  = 2'd1
  } reg_idx_e;

  typedef struct packed {
    kind_e              kind;
    logic [SpaceW-1:0]  left_space;
    logic [SpaceW-1:0]  right_space;
    logic [ByteW-1:0]   data_byte;
    cmd_e               cmd;
    logic [CountW-1:0]  count;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]  fill_value;
    logic [WidthW-1:0] run_length;
    logic              row_done;
    logic              width_mismatch;
    logic              bad_code;
  } result_t;

endpackage

### rtl/smrd_front.sv
// Front end: accepts items and classifies them for the execution queue.
`timescale 1ns / 1ps
module smrd_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [smrd_pkg::SpaceW-1:0]   left_space_i,
  input  logic [smrd_pkg::SpaceW-1:0]   right_space_i,
  input  logic [smrd_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output smrd_pkg::item_t               q_item_o
);

  logic blank_row;

  assign in_stall_o = q_full_i;
  assign blank_row  = (left_space_i == smrd_pkg::BlankRowMark) ||
                      (right_space_i == smrd_pkg::BlankRowMark);

  always_comb begin
    q_item_o.left_space  = left_space_i;
    q_item_o.right_space = right_space_i;
    q_item_o.data_byte   = data_byte_i;
    q_item_o.cmd         = smrd_pkg::cmd_e'(data_byte_i[1:0]);
    q_item_o.count       = {1'b0, data_byte_i[7:2]} + 7'd1;
    q_item_o.kind        = smrd_pkg::KIND_LAYER;
    q_push_o             = 1'b0;
    case (smrd_pkg::op_e'(op_i))
      smrd_pkg::OP_LAYER_START: begin
        q_item_o.kind = smrd_pkg::KIND_LAYER;
        q_push_o      = in_valid_i && !q_full_i;
      end
      smrd_pkg::OP_ROW_BEGIN: begin
        q_item_o.kind = blank_row ? smrd_pkg::KIND_BLANK_ROW : smrd_pkg::KIND_ROW;
        q_push_o      = in_valid_i && !q_full_i;
      end
      smrd_pkg::OP_STREAM_BYTE: begin
        q_item_o.kind = smrd_pkg::KIND_BYTE;
        q_push_o      = in_valid_i && !q_full_i;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/smrd_queue.sv
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps
module smrd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  smrd_pkg::item_t  item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output smrd_pkg::item_t  item_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  smrd_pkg::item_t         mem_q [Depth];
  logic [PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]           count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/smrd_back.sv
// Back end: row state, run generation and the output register.
`timescale 1ns / 1ps
module smrd_back #(
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smrd_pkg::WidthW-1:0]   cfg_wdata_i,
  input  logic                          q_valid_i,
  input  smrd_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output smrd_pkg::result_t             out_res_o
);

  localparam int unsigned SumW = smrd_pkg::WidthW + 1;
  localparam logic [SumW-1:0] ColMax = SumW'((32'd1 << COLUMN_BITS) - 32'd1);

  logic [smrd_pkg::WidthW-1:0]  width_q;
  logic                         kind_q;

  logic [smrd_pkg::CountW-1:0]  pbl_q, pbl_d;
  logic [COLUMN_BITS-1:0]       column_q, column_d;
  logic [smrd_pkg::SpaceW-1:0]  right_edge_q, right_edge_d;
  logic                         row_open_q, row_open_d;
  logic                         err_q, err_d;

  logic                         out_valid_q;
  smrd_pkg::result_t            out_res_q;

  logic                         emit;
  smrd_pkg::result_t            res;
  logic [smrd_pkg::ByteW-1:0]   bg;
  logic [smrd_pkg::WidthW-1:0]  col16;
  logic [SumW-1:0]              adv_base;
  logic [smrd_pkg::WidthW-1:0]  adv_n;
  logic [SumW-1:0]              adv_sum;
  logic [COLUMN_BITS-1:0]       adv_col;
  logic [SumW-1:0]              edge_sum;
  logic                         mis;
  logic [smrd_pkg::WidthW-1:0]  fill_len;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign bg       = kind_q ? smrd_pkg::ZeroGray : smrd_pkg::FullGray;
  assign col16    = smrd_pkg::WidthW'(column_q);
  assign edge_sum = SumW'(col16) + SumW'(right_edge_q);
  assign fill_len = (width_q > col16) ? width_q - col16 : '0;

  always_comb begin
    mis = (edge_sum != SumW'(width_q));
    if (!kind_q && (edge_sum + SumW'(1) == SumW'(width_q))) begin
      mis = 1'b0;
    end
  end

  always_comb begin
    adv_base = SumW'(col16);
    adv_n    = smrd_pkg::WidthW'(q_item_i.count);
    case (q_item_i.kind)
      smrd_pkg::KIND_ROW: begin
        adv_base = '0;
        adv_n    = q_item_i.left_space;
      end
      smrd_pkg::KIND_BYTE: begin
        if (q_item_i.cmd == smrd_pkg::CMD_END_ROW) begin
          adv_n = fill_len;
        end
      end
      default: begin
        adv_n = smrd_pkg::WidthW'(q_item_i.count);
      end
    endcase
    adv_sum = adv_base + SumW'(adv_n);
    adv_col = (adv_sum > ColMax) ? ColMax[COLUMN_BITS-1:0] : adv_sum[COLUMN_BITS-1:0];
  end

  always_comb begin
    pbl_d        = pbl_q;
    column_d     = column_q;
    right_edge_d = right_edge_q;
    row_open_d   = row_open_q;
    err_d        = err_q;
    emit         = 1'b0;
    res          = '0;
    res.fill_value = bg;
    if (q_pop_o) begin
      if (q_item_i.kind == smrd_pkg::KIND_LAYER) begin
        pbl_d        = '0;
        column_d     = '0;
        right_edge_d = '0;
        row_open_d   = 1'b0;
        err_d        = 1'b0;
      end else if (!err_q) begin
        case (q_item_i.kind)
          smrd_pkg::KIND_BLANK_ROW: begin
            pbl_d          = '0;
            row_open_d     = 1'b0;
            column_d       = '0;
            right_edge_d   = '0;
            emit           = 1'b1;
            res.run_length = width_q;
            res.row_done   = 1'b1;
          end
          smrd_pkg::KIND_ROW: begin
            pbl_d          = '0;
            row_open_d     = 1'b1;
            right_edge_d   = q_item_i.right_space;
            column_d       = adv_col;
            emit           = (q_item_i.left_space != '0);
            res.run_length = q_item_i.left_space;
          end
          smrd_pkg::KIND_BYTE: begin
            if (row_open_q) begin
              if (pbl_q != '0) begin
                pbl_d          = pbl_q - 1'b1;
                emit           = 1'b1;
                res.fill_value = ~q_item_i.data_byte;
                res.run_length = smrd_pkg::WidthW'(1);
              end else begin
                case (q_item_i.cmd)
                  smrd_pkg::CMD_BG_RUN: begin
                    column_d       = adv_col;
                    emit           = 1'b1;
                    res.run_length = smrd_pkg::WidthW'(q_item_i.count);
                  end
                  smrd_pkg::CMD_DRAW: begin
                    column_d       = adv_col;
                    res.fill_value = smrd_pkg::FullGray;
                    res.run_length = smrd_pkg::WidthW'(q_item_i.count);
                    if (!kind_q) begin
                      pbl_d = q_item_i.count;
                    end else begin
                      emit = 1'b1;
                    end
                  end
                  smrd_pkg::CMD_BAD: begin
                    err_d          = 1'b1;
                    row_open_d     = 1'b0;
                    pbl_d          = '0;
                    emit           = 1'b1;
                    res.fill_value = smrd_pkg::ZeroGray;
                    res.row_done   = 1'b1;
                    res.bad_code   = 1'b1;
                  end
                  default: begin
                    row_open_d         = 1'b0;
                    column_d           = adv_col;
                    emit               = 1'b1;
                    res.run_length     = fill_len;
                    res.row_done       = 1'b1;
                    res.width_mismatch = mis;
                  end
                endcase
              end
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= '0;
      kind_q       <= 1'b0;
      pbl_q        <= '0;
      column_q     <= '0;
      right_edge_q <= '0;
      row_open_q   <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == smrd_pkg::REG_LAYER_WIDTH)) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == smrd_pkg::REG_LAYER_KIND)) begin
        kind_q <= cfg_wdata_i[0];
      end
      pbl_q        <= pbl_d;
      column_q     <= column_d;
      right_edge_q <= right_edge_d;
      row_open_q   <= row_open_d;
      err_q        <= err_d;
      if (q_pop_o) begin
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_res_q <= res;
    end
  end

endmodule

### rtl/sprite_mask_rle_row_decoder_core.sv
// Top level of the sprite mask run-length row decoder.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  op, left_space, right_space, data_byte
//   out      output     out_valid_o/out_stall_i fill_value, run_length, row_done,
//                                             width_mismatch, bad_code
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the queue has room; each result is registered in the
// output register. The back end executes one queued item per cycle unless stalled.
// A two-entry queue holds up to two items while the output stalls.
// Reset clears all row state, the configuration registers and the queue.
`timescale 1ns / 1ps
module sprite_mask_rle_row_decoder_core #(
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smrd_pkg::WidthW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [smrd_pkg::SpaceW-1:0]   left_space_i,
  input  logic [smrd_pkg::SpaceW-1:0]   right_space_i,
  input  logic [smrd_pkg::ByteW-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [smrd_pkg::ByteW-1:0]    fill_value_o,
  output logic [smrd_pkg::WidthW-1:0]   run_length_o,
  output logic                          row_done_o,
  output logic                          width_mismatch_o,
  output logic                          bad_code_o
);

  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  smrd_pkg::item_t    push_item;
  smrd_pkg::item_t    head_item;
  smrd_pkg::result_t  res;

  smrd_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .left_space_i  (left_space_i),
    .right_space_i (right_space_i),
    .data_byte_i   (data_byte_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  smrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (head_item)
  );

  smrd_back #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign fill_value_o     = res.fill_value;
  assign run_length_o     = res.run_length;
  assign row_done_o       = res.row_done;
  assign width_mismatch_o = res.width_mismatch;
  assign bad_code_o       = res.bad_code;

endmodule

### rtl/smrd_checker.sv
// Port-level checks for the row decoder and their binding to the top level.
`timescale 1ns / 1ps
module smrd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [smrd_pkg::ByteW-1:0]   fill_value_o,
  input  logic [smrd_pkg::WidthW-1:0]  run_length_o,
  input  logic                         row_done_o,
  input  logic                         width_mismatch_o,
  input  logic                         bad_code_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(run_length_o))
    else $error("stalled item dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_code_o |->
      row_done_o && (run_length_o == '0) && (fill_value_o == smrd_pkg::ZeroGray))
    else $error("bad code item malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && width_mismatch_o |-> row_done_o && !bad_code_o)
    else $error("width mismatch outside end of row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_done_o |-> (run_length_o != '0))
    else $error("empty run inside a row");

endmodule

bind sprite_mask_rle_row_decoder_core smrd_checker u_smrd_checker (.*);
